@@ src/bws_pkg.sv @@
`timescale 1ns / 1ps
package bws_pkg;
  localparam int MAX_ROWS_D   = 128;
  localparam int MAX_COLS_D   = 128;
  localparam int MAX_FRAMES_D = 4;
  localparam int FRAC_BITS_D  = 8;
  localparam int PIXEL_BITS_D = 16;
  localparam int COORD_W      = 18;

  // register addresses (byte)
  localparam logic [3:0] REG_ROWS   = 4'h0;
  localparam logic [3:0] REG_COLS   = 4'h4;
  localparam logic [3:0] REG_FRAMES = 4'h8;
  localparam logic [3:0] REG_FILL   = 4'hC;

  // function codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load_wr;   // write the input pixel
    logic setup;     // capture request, compute base and weights
    logic rd;        // issue reads for frame
    logic mac;       // not read by the datapath
    logic emit;      // register result
    logic [1:0] tap; // neighbor index for rd
  } bws_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_frame;
  } bws_sts_t;
endpackage

@@ src/bws_datapath.sv @@
`timescale 1ns / 1ps
module bws_datapath #(
  parameter int MAX_ROWS   = bws_pkg::MAX_ROWS_D,
  parameter int MAX_COLS   = bws_pkg::MAX_COLS_D,
  parameter int MAX_FRAMES = bws_pkg::MAX_FRAMES_D,
  parameter int FRAC_BITS  = bws_pkg::FRAC_BITS_D,
  parameter int PIXEL_BITS = bws_pkg::PIXEL_BITS_D
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bws_pkg::bws_cmd_t            cmd,
  output bws_pkg::bws_sts_t            sts,
  input  logic [6:0]                   pix_row,
  input  logic [6:0]                   pix_col,
  input  logic [1:0]                   pix_frame,
  input  logic signed [PIXEL_BITS-1:0] pixel_value,
  input  logic signed [17:0]           x_coord,
  input  logic signed [17:0]           y_coord,
  input  logic [7:0]                   num_rows,
  input  logic [7:0]                   num_cols,
  input  logic [2:0]                   num_frames,
  input  logic signed [PIXEL_BITS-1:0] fill_value,
  output logic signed [PIXEL_BITS-1:0] res_value,
  output logic                         res_in_range,
  output logic [1:0]                   res_frame,
  output logic                         res_last
);
  import bws_pkg::*;

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int AW = FW + RW + CW;
  localparam int DEPTH = MAX_FRAMES * MAX_ROWS * MAX_COLS;
  localparam int SW = 2 * FRAC_BITS + 2;        // weight width incl sign slack
  localparam int PW = PIXEL_BITS + 2 * FRAC_BITS + 2;
  localparam int ACCW = PW + 3;
  localparam int IW = COORD_W - FRAC_BITS + 1;  // integer part width

  logic signed [PIXEL_BITS-1:0] mem [DEPTH];
  logic signed [PIXEL_BITS-1:0] rd_data_r;

  // effective dims
  logic [12:0] rows_e, cols_e;
  logic [4:0]  frames_e;
  always_comb begin
    rows_e = (13'(num_rows) > 13'(MAX_ROWS)) ? 13'(MAX_ROWS) : 13'(num_rows);
    cols_e = (13'(num_cols) > 13'(MAX_COLS)) ? 13'(MAX_COLS) : 13'(num_cols);
    frames_e = (num_frames == 3'd0) ? 5'd1 : 5'(num_frames);
    if (frames_e > 5'(MAX_FRAMES)) frames_e = 5'(MAX_FRAMES);
  end

  // base position and fractions from the request
  logic signed [COORD_W:0] xb, yb;
  logic signed [IW-1:0] colv, rowv;
  logic base_in;
  assign xb = {x_coord[COORD_W-1], x_coord} - (COORD_W+1)'(1 << FRAC_BITS);
  assign yb = {y_coord[COORD_W-1], y_coord} - (COORD_W+1)'(1 << FRAC_BITS);
  assign colv = xb[COORD_W:FRAC_BITS];
  assign rowv = yb[COORD_W:FRAC_BITS];
  assign base_in = !colv[IW-1] && !rowv[IW-1]
               && (colv < $signed({1'b0, 13'(cols_e)}))
               && (rowv < $signed({1'b0, 13'(rows_e)}));

  logic [CW-1:0] c0_r, c1_r;
  logic [RW-1:0] r0_r, r1_r;
  logic [FRAC_BITS:0] fx_r, fy_r;
  logic inside_r;
  logic [FW-1:0] frame_r;
  logic [4:0] nfr_r;
  logic [SW-1:0] w_r [4];
  logic signed [ACCW-1:0] acc_r;
  logic signed [PW-1:0] prod_r;
  logic [1:0] ptap_r;
  logic pvalid_r;

  // capture request
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      c0_r <= CW'(colv);
      r0_r <= RW'(rowv);
      c1_r <= (13'(colv) + 13'd1 < cols_e) ? CW'(colv + 1) : CW'(colv);
      r1_r <= (13'(rowv) + 13'd1 < rows_e) ? RW'(rowv + 1) : RW'(rowv);
      fx_r <= {1'b0, xb[FRAC_BITS-1:0]};
      fy_r <= {1'b0, yb[FRAC_BITS-1:0]};
      inside_r <= base_in;
      nfr_r <= frames_e;
    end
  end

  // weights, one multiply each from the captured fractions
  logic [FRAC_BITS:0] sfx, sfy;
  assign sfx = (FRAC_BITS+1)'(1 << FRAC_BITS) - fx_r;
  assign sfy = (FRAC_BITS+1)'(1 << FRAC_BITS) - fy_r;
  always_ff @(posedge clk) begin
    w_r[0] <= SW'(sfx * sfy);
    w_r[1] <= SW'(fx_r * sfy);
    w_r[2] <= SW'(sfx * fy_r);
    w_r[3] <= SW'(fx_r * fy_r);
  end

  // frame counter
  always_ff @(posedge clk) begin
    if (!rst_n) frame_r <= '0;
    else if (cmd.setup) frame_r <= '0;
    else if (cmd.emit) frame_r <= frame_r + FW'(1);
  end
  assign sts.last_frame = (5'(frame_r) + 5'd1 >= nfr_r);

  // memory read/write
  logic [AW-1:0] rd_addr, wr_addr;
  always_comb begin
    case (cmd.tap)
      2'd0: rd_addr = {frame_r, r0_r, c0_r};
      2'd1: rd_addr = {frame_r, r0_r, c1_r};
      2'd2: rd_addr = {frame_r, r1_r, c0_r};
      2'd3: rd_addr = {frame_r, r1_r, c1_r};
      default: rd_addr = '0;
    endcase
  end
  assign wr_addr = {FW'(pix_frame), RW'(pix_row), CW'(pix_col)};
  logic wr_ok;
  assign wr_ok = (32'(pix_row) < 32'(MAX_ROWS)) && (32'(pix_col) < 32'(MAX_COLS))
              && (32'(pix_frame) < 32'(MAX_FRAMES));
  logic [1:0] rtap_r;
  logic rvalid_r;
  always_ff @(posedge clk) begin
    if (cmd.load_wr && wr_ok) mem[wr_addr] <= pixel_value;
    rd_data_r <= mem[rd_addr];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvalid_r <= 1'b0; pvalid_r <= 1'b0;
    end else begin
      rvalid_r <= cmd.rd; pvalid_r <= rvalid_r;
    end
  end
  always_ff @(posedge clk) rtap_r <= cmd.tap;

  // multiply stage
  always_ff @(posedge clk) begin
    prod_r <= PW'($signed({1'b0, w_r[rtap_r]}) * rd_data_r);
    ptap_r <= rtap_r;
  end

  // accumulate
  always_ff @(posedge clk) begin
    if (pvalid_r) begin
      if (ptap_r == 2'd0) acc_r <= ACCW'(prod_r);
      else acc_r <= acc_r + ACCW'(prod_r);
    end
  end

  // round, saturate, register
  logic signed [ACCW-1:0] rnd, q;
  logic signed [PIXEL_BITS-1:0] sat;
  localparam logic signed [ACCW-1:0] PMAX = ACCW'((64'sd1 <<< (PIXEL_BITS-1)) - 1);
  localparam logic signed [ACCW-1:0] PMIN = -PMAX - ACCW'(1);
  always_comb begin
    rnd = acc_r + ACCW'(1 << (2*FRAC_BITS-1));
    q = rnd >>> (2*FRAC_BITS);
    if (q > PMAX) sat = PIXEL_BITS'(PMAX);
    else if (q < PMIN) sat = PIXEL_BITS'(PMIN);
    else sat = PIXEL_BITS'(q);
  end
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res_value <= inside_r ? sat : fill_value;
      res_in_range <= inside_r;
      res_frame <= 2'(frame_r);
      res_last <= sts.last_frame;
    end
  end
endmodule

@@ src/bws_ctrl.sv @@
`timescale 1ns / 1ps
module bws_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic               in_func,
  output logic               in_ready,
  output logic               res_valid,
  input  logic               res_ready,
  output bws_pkg::bws_cmd_t  cmd,
  input  bws_pkg::bws_sts_t  sts
);
  import bws_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_WGT  = 5'b00010,
    S_RD   = 5'b00100,
    S_WAIT = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] tap_r, tap_nxt;
  logic [1:0] wcnt_r, wcnt_nxt;
  logic res_valid_r, res_valid_nxt;

  assign in_ready = (state_r == S_IDLE);
  assign res_valid = res_valid_r;

  // sequencing: weights, four reads, pipeline drain, emit
  always_comb begin
    state_nxt = state_r;
    tap_nxt = tap_r;
    wcnt_nxt = wcnt_r;
    res_valid_nxt = res_valid_r && !res_ready;
    cmd = '0;
    cmd.tap = tap_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_func == FUNC_LOAD) cmd.load_wr = 1'b1;
          else begin
            cmd.setup = 1'b1;
            state_nxt = S_WGT;
          end
        end
      end
      S_WGT: begin
        tap_nxt = 2'd0;
        state_nxt = S_RD;
      end
      S_RD: begin
        cmd.rd = 1'b1;
        tap_nxt = tap_r + 2'd1;
        if (tap_r == 2'd3) begin
          wcnt_nxt = 2'd0;
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        wcnt_nxt = wcnt_r + 2'd1;
        if (wcnt_r == 2'd2) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!res_valid_r || res_ready) begin
          cmd.emit = 1'b1;
          res_valid_nxt = 1'b1;
          tap_nxt = 2'd0;
          state_nxt = sts.last_frame ? S_IDLE : S_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tap_r <= 2'd0;
      wcnt_r <= 2'd0;
      res_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tap_r <= tap_nxt;
      wcnt_r <= wcnt_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // requests only taken while idle
  a_fire_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> state_r == S_IDLE) else $error("request taken while busy");
  // emit only from output state
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> state_r == S_OUT) else $error("emit outside output state");
  // a sample request starts the weight step
  a_setup: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.setup |=> state_r == S_WGT) else $error("setup not followed by weights");
endmodule

@@ src/bilinear_warp_sampler_top.sv @@
`timescale 1ns / 1ps
// bilinear warp sampler
// in_ channel: a request either loads one pixel (func 0) or asks for one
// sample (func 1) at 1-based fixed-point x/y with 8 fraction bits.
// out_ channel: one result per frame in use, tlast on the final frame.
// a load writes one pixel and gives no result; loads can follow back to back.
// a sample first computes its weights after it is taken, then per frame
// issues four reads of the image store, drains the read, multiply and
// accumulate stages and emits one result; no new request is taken until
// the result for the last frame has been emitted.
// results sit in an output register; when the receiver stalls the block
// holds the result and waits before its next emit, which stretches the
// sequence by the stall; once the last emit is done requests are taken
// again while that result still waits.
// reset (rst_n low, synchronous) restores the registers to 128 rows,
// 128 columns, 1 frame, fill 0; the image store is not cleared.
// config: apb-style, 0x0 rows, 0x4 cols, 0x8 frames, 0xC fill value.
module bilinear_warp_sampler_top #(
  parameter int MAX_ROWS   = bws_pkg::MAX_ROWS_D,
  parameter int MAX_COLS   = bws_pkg::MAX_COLS_D,
  parameter int MAX_FRAMES = bws_pkg::MAX_FRAMES_D,
  parameter int FRAC_BITS  = bws_pkg::FRAC_BITS_D
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: pix_row[6:0], pix_col[13:7], pix_frame[15:14], pixel_value[31:16],
  //        x_coord[49:32], y_coord[67:50], zero pad to 72
  input  logic [71:0] in_tdata,
  // tuser: func
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: sample_value[15:0]
  output logic [15:0] out_tdata,
  // tuser: in_range[0], out_frame[2:1]
  output logic [2:0]  out_tuser,
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import bws_pkg::*;

  logic [7:0] rows_r, cols_r;
  logic [2:0] frames_r;
  logic signed [15:0] fill_r;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= 8'd128; cols_r <= 8'd128; frames_r <= 3'd1; fill_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr)
        REG_ROWS:   rows_r <= cfg_pwdata[7:0];
        REG_COLS:   cols_r <= cfg_pwdata[7:0];
        REG_FRAMES: frames_r <= cfg_pwdata[2:0];
        REG_FILL:   fill_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr)
      REG_ROWS:   cfg_prdata = {24'd0, rows_r};
      REG_COLS:   cfg_prdata = {24'd0, cols_r};
      REG_FRAMES: cfg_prdata = {29'd0, frames_r};
      REG_FILL:   cfg_prdata = {16'd0, fill_r};
      default:    cfg_prdata = '0;
    endcase
  end

  bws_cmd_t cmd;
  bws_sts_t sts;
  logic in_fire;
  logic [1:0] res_frame;
  logic res_in_range;
  assign in_fire = in_tvalid && in_tready;

  bws_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_func(in_tuser),
    .in_ready(in_tready), .res_valid(out_tvalid), .res_ready(out_tready),
    .cmd(cmd), .sts(sts)
  );

  bws_datapath #(
    .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .MAX_FRAMES(MAX_FRAMES),
    .FRAC_BITS(FRAC_BITS), .PIXEL_BITS(PIXEL_BITS_D)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .pix_row(in_tdata[6:0]), .pix_col(in_tdata[13:7]),
    .pix_frame(in_tdata[15:14]), .pixel_value(in_tdata[31:16]),
    .x_coord(in_tdata[49:32]), .y_coord(in_tdata[67:50]),
    .num_rows(rows_r), .num_cols(cols_r), .num_frames(frames_r),
    .fill_value(fill_r),
    .res_value(out_tdata), .res_in_range(res_in_range),
    .res_frame(res_frame), .res_last(out_tlast)
  );

  assign out_tuser = {res_frame, res_in_range};
endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import bws_pkg::*;

  localparam int IDX_ROWS = 0;
  localparam int IDX_COLS = 1;
  localparam int IDX_FRAMES = 2;
  localparam int IDX_FILL = 3;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic signed [15:0] value;
    logic               in_range;
    logic [1:0]         frame;
    logic               last;
  } sample_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  bilinear_warp_sampler_top uut (.*);

  // shadow of the block's state
  logic signed [15:0] pix_mem [0:3][0:127][0:127];
  logic [7:0]         rows_reg;
  logic [7:0]         cols_reg;
  logic [2:0]         frames_reg;
  logic signed [15:0] fill_reg;

  sample_t samples_due[$];
  int      errors;
  int      idle_cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // watchdog on handshake progress
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n || cfg_psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver with random stalls
  initial begin
    int gap;
    out_tready = 1'b0;
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    sample_t exp_s;
    if (rst_n && out_tvalid && out_tready) begin
      if (samples_due.size() == 0) begin
        $error("unexpected result value %0d", $signed(out_tdata));
        errors++;
      end else begin
        exp_s = samples_due.pop_front();
        if (out_tdata !== exp_s.value) begin
          $error("sample_value exp %0d got %0d", exp_s.value, $signed(out_tdata));
          errors++;
        end
        if (out_tuser[0] !== exp_s.in_range) begin
          $error("in_range exp %0d got %0d", exp_s.in_range, out_tuser[0]);
          errors++;
        end
        if (out_tuser[2:1] !== exp_s.frame) begin
          $error("out_frame exp %0d got %0d", exp_s.frame, out_tuser[2:1]);
          errors++;
        end
        if (out_tlast !== exp_s.last) begin
          $error("last exp %0d got %0d", exp_s.last, out_tlast);
          errors++;
        end
      end
    end
  end

  // interpolate all frames of one sample request
  task automatic predict_samples(input logic signed [17:0] x, input logic signed [17:0] y);
    longint rows, cols, frames, xb, yb, col, row, fx, fy, sum, t, q;
    longint c1, r1;
    bit in_img;
    sample_t s;
    rows = (rows_reg > 128) ? 128 : rows_reg;
    cols = (cols_reg > 128) ? 128 : cols_reg;
    frames = (frames_reg == 0) ? 1 : ((frames_reg > 4) ? 4 : frames_reg);
    xb = longint'(x) - 256;
    yb = longint'(y) - 256;
    col = xb >>> 8;
    row = yb >>> 8;
    fx = xb - col * 256;
    fy = yb - row * 256;
    in_img = col >= 0 && col < cols && row >= 0 && row < rows;
    for (int f = 0; f < frames; f++) begin
      if (in_img) begin
        c1 = (col + 1 < cols) ? col + 1 : col;
        r1 = (row + 1 < rows) ? row + 1 : row;
        sum = (256 - fx) * (256 - fy) * pix_mem[f][row][col]
            + fx * (256 - fy) * pix_mem[f][row][c1]
            + (256 - fx) * fy * pix_mem[f][r1][col]
            + fx * fy * pix_mem[f][r1][c1];
        t = sum + 32768;
        q = t >>> 16;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        s.value = q[15:0];
      end else begin
        s.value = fill_reg;
      end
      s.in_range = in_img;
      s.frame = f[1:0];
      s.last = (f + 1 == frames);
      samples_due.push_back(s);
    end
  endtask

  // send one request after a random gap
  task automatic send_request(input logic func, input logic [6:0] r, input logic [6:0] c,
                              input logic [1:0] fr, input logic [15:0] pv,
                              input logic [17:0] x, input logic [17:0] y);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= {4'b0, y, x, pv, fr, c, r};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (func == FUNC_LOAD) begin
      pix_mem[fr][r][c] = pv;
    end else begin
      predict_samples(x, y);
    end
  endtask

  task automatic load_pixel(input int f, input int r, input int c, input logic [15:0] v);
    send_request(FUNC_LOAD, r[6:0], c[6:0], f[1:0], v, 18'($urandom), 18'($urandom));
  endtask

  task automatic sample_at(input logic [17:0] x, input logic [17:0] y);
    send_request(FUNC_SAMPLE, 7'($urandom), 7'($urandom), 2'($urandom), 16'($urandom),
                 x, y);
  endtask

  // wait until every result is back, then let the block settle
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (samples_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input int idx, input logic [31:0] v);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 4'(idx * 4);
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      IDX_ROWS:   rows_reg = v[7:0];
      IDX_COLS:   cols_reg = v[7:0];
      IDX_FRAMES: frames_reg = v[2:0];
      default:    fill_reg = v[15:0];
    endcase
  endtask

  task automatic set_geometry(input int r, input int c, input int f, input logic [15:0] fill);
    write_reg(IDX_ROWS, r);
    write_reg(IDX_COLS, c);
    write_reg(IDX_FRAMES, f);
    write_reg(IDX_FILL, {16'b0, fill});
  endtask

  // fill the used area of every frame so no sample reads unwritten pixels
  task automatic fill_image(input int r, input int c, input bit extremes);
    logic [15:0] v;
    for (int f = 0; f < 4; f++)
      for (int i = 0; i < r; i++)
        for (int j = 0; j < c; j++) begin
          if (extremes) v = ($urandom_range(0, 1)) ? 16'h7fff : 16'h8000;
          else v = 16'($urandom);
          load_pixel(f, i, j, v);
        end
  endtask

  // random coordinate, mostly inside the image, sometimes anywhere
  function automatic logic [17:0] pick_coord(input int dim);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 18'($urandom);
    if (pick == 1) return 18'($signed($urandom_range(0, 512)) - 256);
    if (pick == 2) return 18'((dim + 1) * 256 + $urandom_range(0, 255));
    return 18'($urandom_range(256, dim * 256 + 255));
  endfunction

  // directed: corners, edges, extremes and out-of-image cases
  task automatic test_directed();
    set_geometry(2, 2, 4, 16'h8000);
    fill_image(2, 2, 1);
    sample_at(18'h00100, 18'h00100);
    sample_at(18'h00180, 18'h00180);
    sample_at(18'h002ff, 18'h002ff);
    sample_at(18'h000ff, 18'h00100);
    sample_at(18'h00100, 18'h000ff);
    sample_at(18'h00300, 18'h00100);
    sample_at(18'h20000, 18'h1ffff);
    sample_at(18'h1ffff, 18'h20000);
    sample_at(18'h001ff, 18'h001ff);
    drain_results();
    // rows/cols zero: always outside, frame count zero acts as one
    set_geometry(0, 0, 0, 16'h7fff);
    sample_at(18'h00100, 18'h00100);
    drain_results();
    // frame count above range saturates
    set_geometry(2, 2, 7, 16'h1234);
    sample_at(18'h00140, 18'h001c0);
    sample_at(18'h00000, 18'h00000);
    drain_results();
    // dimensions above range saturate
    set_geometry(255, 200, 1, 16'h0000);
    sample_at(18'h00100, 18'h00100);
    drain_results();
  endtask

  // random: loads and samples mixed within one geometry
  task automatic test_random(input int r, input int c, input int f, input int count);
    int f_pick;
    int i;
    int j;
    set_geometry(r, c, f, 16'($urandom));
    fill_image(r, c, 0);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 4) == 0) begin
        f_pick = $urandom_range(0, 3);
        i = $urandom_range(0, r - 1);
        j = $urandom_range(0, c - 1);
        load_pixel(f_pick, i, j, 16'($urandom));
      end else begin
        sample_at(pick_coord(c), pick_coord(r));
      end
    end
    drain_results();
  endtask

  initial begin
    errors = 0;
    idle_cycles = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    rows_reg = 128;
    cols_reg = 128;
    frames_reg = 1;
    fill_reg = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(3, 4, 4, 40);
    test_random(1, 1, 2, 30);
    test_random(5, 2, 3, 40);
    test_random(4, 6, 1, 35);
    drain_results();
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
